FILE: hdl/sgcc_pkg.sv
`default_nettype none

package sgcc_pkg;

    localparam int COORD_X_W           = 27;
    localparam int COORD_Y_W           = 26;
    localparam int SIZE_W              = 22;
    localparam int CELL_INDEX_BITS_DEF = 16;

    localparam int DX_W    = COORD_X_W + 1;
    localparam int DY_W    = COORD_Y_W + 1;
    localparam int CLAMP_W = 29;
    localparam int PROD_W  = CLAMP_W + DX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_X_W;

    localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = SIZE_W'(36000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_LON = 2'd0,
        CFG_ORIGIN_LAT = 2'd1,
        CFG_CELL_SIZE  = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hdl/segment_grid_cell_crossing.sv
// throughput: one item per cycle while m_tready is high; five register stages
// (cell multiply, box add, offset and clamp, two 29x28 and two 29x27 products,
// compare), each stage stalls on its own
// aresetn (synchronous, active low) empties the pipeline and sets origin_lon and
// origin_lat to 0 and cell_size to 36000
`default_nettype none

module segment_grid_cell_crossing #(
    parameter int CELL_INDEX_BITS = sgcc_pkg::CELL_INDEX_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sgcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sgcc_pkg::CFG_DATA_W-1:0] cfg_data,
    // item in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, end_x, end_y, cell_col, cell_row, zero pad
    input  wire logic [((106 + 2 * CELL_INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // item out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // crosses, zero pad
    output logic [7:0]                           m_tdata
);

    import sgcc_pkg::*;

    localparam int OFF_SY  = COORD_X_W;
    localparam int OFF_EX  = OFF_SY + COORD_Y_W;
    localparam int OFF_EY  = OFF_EX + COORD_X_W;
    localparam int OFF_COL = OFF_EY + COORD_Y_W;
    localparam int OFF_ROW = OFF_COL + CELL_INDEX_BITS;
    localparam int PC_W    = CELL_INDEX_BITS + SIZE_W;
    localparam int BOX_W   = CELL_INDEX_BITS + 25;
    localparam int DIFF_W  = BOX_W + 1;

    function automatic logic signed [CLAMP_W-1:0] clamp_diff(
        input logic signed [DIFF_W-1:0] v
    );
        logic [DIFF_W-CLAMP_W:0] hi;
        hi = v[DIFF_W-1:CLAMP_W-1];
        if (&hi || ~|hi) begin
            return v[CLAMP_W-1:0];
        end else if (v[DIFF_W-1]) begin
            return {1'b1, {(CLAMP_W-1){1'b0}}};
        end else begin
            return {1'b0, {(CLAMP_W-1){1'b1}}};
        end
    endfunction

    // config registers
    logic signed [COORD_X_W-1:0] origin_lon_reg;
    logic signed [COORD_Y_W-1:0] origin_lat_reg;
    logic [SIZE_W-1:0]           cell_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_lon_reg <= '0;
            origin_lat_reg <= '0;
            cell_size_reg  <= CELL_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ORIGIN_LON: origin_lon_reg <= cfg_data[COORD_X_W-1:0];
                CFG_ORIGIN_LAT: origin_lat_reg <= cfg_data[COORD_Y_W-1:0];
                CFG_CELL_SIZE:  cell_size_reg  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !m_valid_reg || m_tready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_tvalid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) v4_reg      <= v3_reg;
            if (en5) m_valid_reg <= v4_reg;
        end
    end

    // stage 1: cell multiply, segment direction
    logic signed [COORD_X_W-1:0] sx_in, ex_in;
    logic signed [COORD_Y_W-1:0] sy_in, ey_in;
    logic [CELL_INDEX_BITS-1:0]  col_in, row_in;
    logic [PC_W-1:0]             pc_next, pr_next;
    logic signed [DX_W-1:0]      dx_next;
    logic signed [DY_W-1:0]      dy_next;

    assign sx_in   = s_tdata[OFF_SY-1:0];
    assign sy_in   = s_tdata[OFF_EX-1:OFF_SY];
    assign ex_in   = s_tdata[OFF_EY-1:OFF_EX];
    assign ey_in   = s_tdata[OFF_COL-1:OFF_EY];
    assign col_in  = s_tdata[OFF_ROW-1:OFF_COL];
    assign row_in  = s_tdata[OFF_ROW+CELL_INDEX_BITS-1:OFF_ROW];
    assign pc_next = PC_W'(col_in) * PC_W'(cell_size_reg);
    assign pr_next = PC_W'(row_in) * PC_W'(cell_size_reg);
    assign dx_next = DX_W'(ex_in) - DX_W'(sx_in);
    assign dy_next = DY_W'(ey_in) - DY_W'(sy_in);

    logic signed [COORD_X_W-1:0] sx1_reg, ex1_reg;
    logic signed [COORD_Y_W-1:0] sy1_reg, ey1_reg;
    logic [PC_W-1:0]             pc1_reg, pr1_reg;
    logic signed [DX_W-1:0]      dx1_reg;
    logic signed [DY_W-1:0]      dy1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            sx1_reg <= sx_in;
            sy1_reg <= sy_in;
            ex1_reg <= ex_in;
            ey1_reg <= ey_in;
            pc1_reg <= pc_next;
            pr1_reg <= pr_next;
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
        end
    end

    // stage 2: cell box
    logic signed [BOX_W-1:0] x0_next, x1_next, y0_next, y1_next;
    logic signed [BOX_W-1:0] size_ext;

    assign size_ext = BOX_W'($signed({1'b0, cell_size_reg}));
    assign x0_next  = BOX_W'(origin_lon_reg) + BOX_W'($signed({1'b0, pc1_reg}));
    assign y0_next  = BOX_W'(origin_lat_reg) + BOX_W'($signed({1'b0, pr1_reg}));
    assign x1_next  = BOX_W'(origin_lon_reg) + BOX_W'($signed({1'b0, pc1_reg})) + size_ext;
    assign y1_next  = BOX_W'(origin_lat_reg) + BOX_W'($signed({1'b0, pr1_reg})) + size_ext;

    logic signed [COORD_X_W-1:0] sx2_reg, ex2_reg;
    logic signed [COORD_Y_W-1:0] sy2_reg, ey2_reg;
    logic signed [BOX_W-1:0]     x0_2_reg, x1_2_reg, y0_2_reg, y1_2_reg;
    logic signed [DX_W-1:0]      dx2_reg;
    logic signed [DY_W-1:0]      dy2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            ex2_reg  <= ex1_reg;
            ey2_reg  <= ey1_reg;
            x0_2_reg <= x0_next;
            x1_2_reg <= x1_next;
            y0_2_reg <= y0_next;
            y1_2_reg <= y1_next;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
        end
    end

    // stage 3: offsets from the segment ends, span tests, clamp
    logic signed [DIFF_W-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic in_x0_next, in_x1_next, in_y0_next, in_y1_next;

    assign ax0 = DIFF_W'(x0_2_reg) - DIFF_W'(sx2_reg);
    assign ax1 = DIFF_W'(x1_2_reg) - DIFF_W'(sx2_reg);
    assign ay0 = DIFF_W'(y0_2_reg) - DIFF_W'(sy2_reg);
    assign ay1 = DIFF_W'(y1_2_reg) - DIFF_W'(sy2_reg);
    assign bx0 = DIFF_W'(x0_2_reg) - DIFF_W'(ex2_reg);
    assign bx1 = DIFF_W'(x1_2_reg) - DIFF_W'(ex2_reg);
    assign by0 = DIFF_W'(y0_2_reg) - DIFF_W'(ey2_reg);
    assign by1 = DIFF_W'(y1_2_reg) - DIFF_W'(ey2_reg);

    // edge line lies between the two ends, ends included
    assign in_x0_next = !((ax0 > 0) && (bx0 > 0)) && !((ax0 < 0) && (bx0 < 0));
    assign in_x1_next = !((ax1 > 0) && (bx1 > 0)) && !((ax1 < 0) && (bx1 < 0));
    assign in_y0_next = !((ay0 > 0) && (by0 > 0)) && !((ay0 < 0) && (by0 < 0));
    assign in_y1_next = !((ay1 > 0) && (by1 > 0)) && !((ay1 < 0) && (by1 < 0));

    logic signed [CLAMP_W-1:0] cx0_3_reg, cx1_3_reg, cy0_3_reg, cy1_3_reg;
    logic                      in_x0_3_reg, in_x1_3_reg, in_y0_3_reg, in_y1_3_reg;
    logic signed [DX_W-1:0]    dx3_reg;
    logic signed [DY_W-1:0]    dy3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            cx0_3_reg   <= clamp_diff(ax0);
            cx1_3_reg   <= clamp_diff(ax1);
            cy0_3_reg   <= clamp_diff(ay0);
            cy1_3_reg   <= clamp_diff(ay1);
            in_x0_3_reg <= in_x0_next;
            in_x1_3_reg <= in_x1_next;
            in_y0_3_reg <= in_y0_next;
            in_y1_3_reg <= in_y1_next;
            dx3_reg     <= dx2_reg;
            dy3_reg     <= dy2_reg;
        end
    end

    // stage 4: cross products
    logic signed [PROD_W-1:0] pa_next, pb_next, pc4_next, pd_next;

    assign pa_next  = cx0_3_reg * dy3_reg;
    assign pb_next  = cx1_3_reg * dy3_reg;
    assign pc4_next = cy0_3_reg * dx3_reg;
    assign pd_next  = cy1_3_reg * dx3_reg;

    logic signed [PROD_W-1:0] pa4_reg, pb4_reg, pc4_reg, pd4_reg;
    logic in_x0_4_reg, in_x1_4_reg, in_y0_4_reg, in_y1_4_reg;
    logic dx_nz4_reg, dx_pos4_reg, dy_nz4_reg, dy_pos4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            pa4_reg     <= pa_next;
            pb4_reg     <= pb_next;
            pc4_reg     <= pc4_next;
            pd4_reg     <= pd_next;
            in_x0_4_reg <= in_x0_3_reg;
            in_x1_4_reg <= in_x1_3_reg;
            in_y0_4_reg <= in_y0_3_reg;
            in_y1_4_reg <= in_y1_3_reg;
            dx_nz4_reg  <= (dx3_reg != 0);
            dx_pos4_reg <= (dx3_reg > 0);
            dy_nz4_reg  <= (dy3_reg != 0);
            dy_pos4_reg <= (dy3_reg > 0);
        end
    end

    // stage 5: intersection point within each edge
    logic hit_left, hit_right, hit_bottom, hit_top, crosses_next;
    logic crosses_reg;

    always_comb begin
        hit_left   = dx_nz4_reg && in_x0_4_reg &&
                     (dx_pos4_reg ? (pc4_reg <= pa4_reg && pa4_reg <= pd4_reg)
                                  : (pd4_reg <= pa4_reg && pa4_reg <= pc4_reg));
        hit_right  = dx_nz4_reg && in_x1_4_reg &&
                     (dx_pos4_reg ? (pc4_reg <= pb4_reg && pb4_reg <= pd4_reg)
                                  : (pd4_reg <= pb4_reg && pb4_reg <= pc4_reg));
        hit_bottom = dy_nz4_reg && in_y0_4_reg &&
                     (dy_pos4_reg ? (pa4_reg <= pc4_reg && pc4_reg <= pb4_reg)
                                  : (pb4_reg <= pc4_reg && pc4_reg <= pa4_reg));
        hit_top    = dy_nz4_reg && in_y1_4_reg &&
                     (dy_pos4_reg ? (pa4_reg <= pd4_reg && pd4_reg <= pb4_reg)
                                  : (pb4_reg <= pd4_reg && pd4_reg <= pa4_reg));
        // zero-sized cell has degenerate edges
        crosses_next = (cell_size_reg != '0) &&
                       (hit_left || hit_right || hit_bottom || hit_top);
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            crosses_reg <= crosses_next;
        end
    end

    assign m_tdata = {7'b0, crosses_reg};

endmodule

`default_nettype wire
